FILE: rtl/core/rxffp_pkg.sv
// shared constants and types of the receive frame filter and header parser
`default_nettype none
package rxffp_pkg;

  localparam int MaxFrame = 2048;
  localparam int PosW     = $clog2(MaxFrame + 1);

  localparam logic [15:0] EtherArp  = 16'h0806;
  localparam logic [15:0] EtherIpv4 = 16'h0800;
  localparam logic [7:0]  ProtoTcp  = 8'd6;
  localparam logic [7:0]  ProtoUdp  = 8'd17;
  localparam int          MinFrame  = 42;

  localparam logic [47:0] GwMacReset = 48'h525400123456;

  // configuration register indexes
  localparam logic [2:0] RegExpectProtocol = 3'd0;
  localparam logic [2:0] RegLocalPort      = 3'd1;
  localparam logic [2:0] RegRemotePort     = 3'd2;
  localparam logic [2:0] RegRequiredFlags  = 3'd3;
  localparam logic [2:0] RegMaxPayload     = 3'd4;
  localparam logic [2:0] RegGatewayIp      = 3'd5;

  // verdict codes
  localparam logic [2:0] VerdReject   = 3'd0;
  localparam logic [2:0] VerdArp      = 3'd1;
  localparam logic [2:0] VerdTcp      = 3'd2;
  localparam logic [2:0] VerdUdp      = 3'd3;
  localparam logic [2:0] VerdNoFlags  = 3'd4;

  localparam int FifoDepth = 4;
  localparam int FifoAw    = $clog2(FifoDepth);

  typedef struct packed {
    logic        frame_end;
    logic [47:0] gateway_mac;
    logic [11:0] payload_count;
    logic [31:0] ack_number;
    logic [31:0] seq_number;
    logic [7:0]  tcp_flags;
    logic [2:0]  verdict;
    logic [7:0]  payload_byte;
    logic        item_kind;
  } rxffp_item_t;

endpackage
`default_nettype wire

FILE: rtl/core/rxffp_out_fifo.sv
// result queue taking up to two items per cycle and giving one per ready cycle
`default_nettype none
module rxffp_out_fifo (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire [1:0]           push_cnt_i,
  input  rxffp_pkg::rxffp_item_t push_a_i,
  input  rxffp_pkg::rxffp_item_t push_b_i,
  output logic                room_o,
  output logic                valid_o,
  input  wire                 ready_i,
  output rxffp_pkg::rxffp_item_t item_o
);
  import rxffp_pkg::*;

  rxffp_item_t       mem_q [FifoDepth];
  logic [FifoAw-1:0] wr_q, rd_q, wr_next;
  logic [FifoAw:0]   cnt_q;
  logic              pop;

  assign pop     = valid_o & ready_i;
  assign valid_o = cnt_q != '0;
  assign room_o  = cnt_q <= (FifoAw+1)'(FifoDepth - 2);
  assign item_o  = mem_q[rd_q];
  assign wr_next = wr_q + FifoAw'(1);

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) mem_q[wr_q] <= push_a_i;
    if (push_cnt_i == 2'd2) mem_q[wr_next] <= push_b_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + FifoAw'(push_cnt_i);
      if (pop) rd_q <= rd_q + FifoAw'(1);
      cnt_q <= cnt_q + (FifoAw+1)'(push_cnt_i) - (FifoAw+1)'(pop);
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/rx_frame_filter_parser_top.sv
// top level of the receive frame filter and header parser
`default_nettype none
// Receive frame filter: takes an Ethernet frame one byte per transfer, destination
// MAC first, tlast on the final byte. ARP replies from the configured gateway IP
// update the stored gateway MAC; IPv4 TCP/UDP frames with the configured protocol
// and ports are accepted (TCP also needs the required flags) and their payload
// bytes go out as tuser=0 transfers, capped by max_payload and the IP/UDP length.
// After the last byte a summary transfer (tuser=1, tlast=1) gives verdict, flags,
// seq, ack, payload count and the gateway MAC. Each byte is parsed in the cycle it
// is taken, so one byte per cycle is accepted; results go through a four-entry
// queue that drains one transfer per ready cycle, and s_axis_tready_o drops only
// while fewer than two entries are free. Bytes at positions past MaxFrame are
// ignored. Configuration writes land at once and should be done between frames.
module rx_frame_filter_parser_top (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  wire  [7:0]   s_axis_tdata_i,   // frame_byte
  input  wire          s_axis_tlast_i,   // frame_last
  output logic         m_axis_tvalid_o,
  input  wire          m_axis_tready_i,
  // payload_byte, verdict, tcp_flags, seq_number, ack_number, payload_count,
  // gateway_mac, one zero pad bit
  output logic [143:0] m_axis_tdata_o,
  output logic         m_axis_tuser_o,   // item_kind
  output logic         m_axis_tlast_o,   // frame_end
  input  wire          cfg_we_i,
  input  wire  [2:0]   cfg_idx_i,
  input  wire  [31:0]  cfg_data_i
);
  import rxffp_pkg::*;

  // configuration
  logic [7:0]  exp_proto_q, req_flags_q;
  logic [15:0] local_port_q, remote_port_q;
  logic [11:0] max_pay_q;
  logic [31:0] gw_ip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_proto_q   <= ProtoTcp;
      local_port_q  <= 16'd40000;
      remote_port_q <= 16'd80;
      req_flags_q   <= 8'd0;
      max_pay_q     <= 12'd1500;
      gw_ip_q       <= 32'd167772674;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegExpectProtocol: exp_proto_q   <= cfg_data_i[7:0];
        RegLocalPort:      local_port_q  <= cfg_data_i[15:0];
        RegRemotePort:     remote_port_q <= cfg_data_i[15:0];
        RegRequiredFlags:  req_flags_q   <= cfg_data_i[7:0];
        RegMaxPayload:     max_pay_q     <= cfg_data_i[11:0];
        RegGatewayIp:      gw_ip_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // per-frame parse state
  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0] kind_q, kind_d, arp_op_q, arp_op_d, itl_q, itl_d;
  logic [5:0]  ihb_q, ihb_d, l4_q, l4_d;
  logic [47:0] arp_mac_q, arp_mac_d, gw_mac_q, gw_mac_d;
  logic [31:0] arp_ip_q, arp_ip_d, seq_q, seq_d, ack_q, ack_d;
  logic        hok_q, hok_d;
  logic [15:0] sport_q, sport_d, dport_q, dport_d, udpl_q, udpl_d;
  logic [7:0]  flags_q, flags_d;
  logic [11:0] cnt_q, cnt_d;

  logic            accept, room, is_tcp, in_range, l4_go, emit, tcp_ok, udp_ok;
  logic [PosW-1:0] p, q;
  logic [7:0]      b;
  logic [1:0]      push_cnt;
  rxffp_item_t     pay_item, sum_item, push_a, out_item;
  logic [2:0]      verd;

  assign s_axis_tready_o = room;
  assign accept = s_axis_tvalid_i & room;
  assign p      = pos_q;
  assign b      = s_axis_tdata_i;
  assign is_tcp = exp_proto_q == ProtoTcp;
  assign in_range = pos_q < PosW'(MaxFrame);
  assign q      = p - PosW'(14) - PosW'(ihb_d);

  // byte parse, in field order of the headers
  always_comb begin
    kind_d = kind_q; arp_op_d = arp_op_q; itl_d = itl_q; ihb_d = ihb_q;
    arp_mac_d = arp_mac_q; arp_ip_d = arp_ip_q; hok_d = hok_q;
    sport_d = sport_q; dport_d = dport_q; seq_d = seq_q; ack_d = ack_q;
    l4_d = l4_q; flags_d = flags_q; udpl_d = udpl_q;
    l4_go = 1'b0; tcp_ok = 1'b0; udp_ok = 1'b0;
    if (in_range) begin
      if (p == PosW'(12)) kind_d = {b, 8'h00};
      if (p == PosW'(13)) kind_d = {kind_q[15:8], b};
      if (p == PosW'(20)) arp_op_d = {b, 8'h00};
      if (p == PosW'(21)) arp_op_d = {arp_op_q[15:8], b};
      if (p >= PosW'(22) && p <= PosW'(27)) arp_mac_d = {arp_mac_q[39:0], b};
      if (p >= PosW'(28) && p <= PosW'(31)) arp_ip_d = {arp_ip_q[23:0], b};
      if (p == PosW'(14)) begin
        ihb_d = {b[3:0], 2'b00};
        if (b[7:4] != 4'd4 || b[3:0] < 4'd5) hok_d = 1'b0;
      end
      if (p == PosW'(16)) itl_d = {b, 8'h00};
      if (p == PosW'(17)) itl_d = {itl_q[15:8], b};
      if (p == PosW'(23) && (b != exp_proto_q || (b != ProtoTcp && b != ProtoUdp)))
        hok_d = 1'b0;
      l4_go = p >= PosW'(34) && ihb_d >= 6'd20 && p >= PosW'(14) + PosW'(ihb_d);
      if (l4_go) begin
        if (q < PosW'(2)) sport_d = {sport_q[7:0], b};
        else if (q < PosW'(4)) dport_d = {dport_q[7:0], b};
        if (q == PosW'(3) && (sport_d != remote_port_q || dport_d != local_port_q))
          hok_d = 1'b0;
        if (is_tcp) begin
          if (q >= PosW'(4) && q <= PosW'(7)) seq_d = {seq_q[23:0], b};
          if (q >= PosW'(8) && q <= PosW'(11)) ack_d = {ack_q[23:0], b};
          if (q == PosW'(12)) begin
            l4_d = {b[7:4], 2'b00};
            if (b[7:4] < 4'd5) hok_d = 1'b0;
          end
          if (q == PosW'(13)) flags_d = b;
          // payload index below total minus both headers reduces to p-14 < total
          tcp_ok = q >= PosW'(20) && q >= PosW'(l4_d)
                   && (flags_d & req_flags_q) == req_flags_q
                   && (17'(p) - 17'd14) < 17'(itl_d);
        end else begin
          if (q == PosW'(4)) udpl_d = {b, 8'h00};
          if (q == PosW'(5)) udpl_d = {udpl_q[15:8], b};
          udp_ok = q >= PosW'(8) && 17'(q) < 17'(udpl_d);
        end
      end
    end
  end

  assign emit = l4_go && (is_tcp ? tcp_ok : udp_ok) && hok_d
                && kind_d == EtherIpv4 && cnt_q < max_pay_q;
  assign cnt_d = cnt_q + 12'(emit);
  assign pos_d = in_range ? pos_q + PosW'(1) : pos_q;

  // frame summary, from state after this byte
  always_comb begin
    verd     = VerdReject;
    gw_mac_d = gw_mac_q;
    sum_item = '0;
    if (pos_d >= PosW'(MinFrame)) begin
      if (kind_d == EtherArp) begin
        if (arp_op_d == 16'd2 && arp_ip_d == gw_ip_q) begin
          gw_mac_d = arp_mac_d;
          verd     = VerdArp;
        end
      end else if (kind_d == EtherIpv4 && hok_d) begin
        if (is_tcp && pos_d >= PosW'(34) + PosW'(ihb_d)) begin
          verd = ((flags_d & req_flags_q) == req_flags_q) ? VerdTcp : VerdNoFlags;
          sum_item.tcp_flags  = flags_d;
          sum_item.seq_number = seq_d;
          sum_item.ack_number = ack_d;
        end else if (exp_proto_q == ProtoUdp && pos_d >= PosW'(22) + PosW'(ihb_d)) begin
          verd = VerdUdp;
        end
      end
    end
    sum_item.item_kind     = 1'b1;
    sum_item.verdict       = verd;
    sum_item.payload_count = cnt_d;
    sum_item.gateway_mac   = gw_mac_d;
    sum_item.frame_end     = 1'b1;
  end

  always_comb begin
    pay_item              = '0;
    pay_item.payload_byte = b;
  end

  assign push_a   = emit ? pay_item : sum_item;
  assign push_cnt = accept ? (2'(emit) + 2'(s_axis_tlast_i)) : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; kind_q <= '0; arp_op_q <= '0; itl_q <= '0; ihb_q <= '0;
      arp_mac_q <= '0; arp_ip_q <= '0; hok_q <= 1'b1; sport_q <= '0;
      dport_q <= '0; seq_q <= '0; ack_q <= '0; l4_q <= '0; flags_q <= '0;
      udpl_q <= '0; cnt_q <= '0; gw_mac_q <= GwMacReset;
    end else if (accept) begin
      if (s_axis_tlast_i) begin
        // frame done: clear everything but the gateway mac
        pos_q <= '0; kind_q <= '0; arp_op_q <= '0; itl_q <= '0; ihb_q <= '0;
        arp_mac_q <= '0; arp_ip_q <= '0; hok_q <= 1'b1; sport_q <= '0;
        dport_q <= '0; seq_q <= '0; ack_q <= '0; l4_q <= '0; flags_q <= '0;
        udpl_q <= '0; cnt_q <= '0; gw_mac_q <= gw_mac_d;
      end else begin
        pos_q <= pos_d; kind_q <= kind_d; arp_op_q <= arp_op_d; itl_q <= itl_d;
        ihb_q <= ihb_d; arp_mac_q <= arp_mac_d; arp_ip_q <= arp_ip_d;
        hok_q <= hok_d; sport_q <= sport_d; dport_q <= dport_d; seq_q <= seq_d;
        ack_q <= ack_d; l4_q <= l4_d; flags_q <= flags_d; udpl_q <= udpl_d;
        cnt_q <= cnt_d;
      end
    end
  end

  rxffp_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .push_a_i   (push_a),
    .push_b_i   (sum_item),
    .room_o     (room),
    .valid_o    (m_axis_tvalid_o),
    .ready_i    (m_axis_tready_i),
    .item_o     (out_item)
  );

  assign m_axis_tuser_o = out_item.item_kind;
  assign m_axis_tlast_o = out_item.frame_end;
  assign m_axis_tdata_o = {1'b0, out_item.gateway_mac, out_item.payload_count,
                           out_item.ack_number, out_item.seq_number,
                           out_item.tcp_flags, out_item.verdict, out_item.payload_byte};
endmodule
`default_nettype wire

FILE: tb/rx_frame_filter_parser_top_tb.sv
// self-checking testbench of the receive frame filter and header parser
`timescale 1ns / 100ps

module rx_frame_filter_parser_top_tb;
  import rxffp_pkg::*;

  // frame header parser mirror plus the queue of results still owed by the block
  class frame_scoreboard;
    // register copies
    bit [7:0]  proto_cfg;
    bit [15:0] local_port_cfg;
    bit [15:0] remote_port_cfg;
    bit [7:0]  flags_cfg;
    bit [11:0] max_payload_cfg;
    bit [31:0] gateway_ip_cfg;
    // per-frame parse state
    int unsigned pos, ether_kind, ip_hdr_len, ip_len, arp_op, arp_ip;
    int unsigned src_port, dst_port, flags, seq, ack, l4_hdr_len, udp_len, emitted;
    bit [47:0] arp_mac, gw_mac;
    bit hdr_ok;
    rxffp_item_t owed[$];
    int mismatches, checked, payload_seen;
    int verdict_hits[8];

    function new();
      proto_cfg = ProtoTcp; local_port_cfg = 40000; remote_port_cfg = 80;
      flags_cfg = 0; max_payload_cfg = 1500; gateway_ip_cfg = 32'd167772674;
      gw_mac = GwMacReset;
      mismatches = 0; checked = 0; payload_seen = 0;
      foreach (verdict_hits[i]) verdict_hits[i] = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      pos = 0; ether_kind = 0; ip_hdr_len = 0; ip_len = 0; arp_op = 0; arp_ip = 0;
      src_port = 0; dst_port = 0; flags = 0; seq = 0; ack = 0; l4_hdr_len = 0;
      udp_len = 0; emitted = 0; arp_mac = '0; hdr_ok = 1'b1;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        RegExpectProtocol: proto_cfg = val[7:0];
        RegLocalPort:      local_port_cfg = val[15:0];
        RegRemotePort:     remote_port_cfg = val[15:0];
        RegRequiredFlags:  flags_cfg = val[7:0];
        RegMaxPayload:     max_payload_cfg = val[11:0];
        RegGatewayIp:      gateway_ip_cfg = val;
        default: ;
      endcase
    endfunction

    // parse one byte at the current position, owe a payload transfer if it is emitted
    function void parse_byte(int unsigned b);
      int unsigned p, q;
      int idx, avail;
      rxffp_item_t it;
      p = pos;
      if (p == 12) ether_kind = b << 8;
      if (p == 13) ether_kind |= b;
      if (p == 20) arp_op = b << 8;
      if (p == 21) arp_op |= b;
      if (p >= 22 && p <= 27) arp_mac = {arp_mac[39:0], b[7:0]};
      if (p >= 28 && p <= 31) arp_ip = (arp_ip << 8) | b;
      if (p == 14) begin
        if ((b & 8'hF0) != 8'h40) hdr_ok = 0;
        ip_hdr_len = (b & 4'hF) * 4;
        if (ip_hdr_len < 20) hdr_ok = 0;
      end
      if (p == 16) ip_len = b << 8;
      if (p == 17) ip_len |= b;
      if (p == 23 && (b != proto_cfg || (b != ProtoTcp && b != ProtoUdp))) hdr_ok = 0;
      if (p < 34 || ip_hdr_len < 20 || p < 14 + ip_hdr_len) return;
      q = p - 14 - ip_hdr_len;
      if (q < 2) src_port = ((src_port << 8) | b) & 16'hFFFF;
      else if (q < 4) dst_port = ((dst_port << 8) | b) & 16'hFFFF;
      if (q == 3 && (src_port != remote_port_cfg || dst_port != local_port_cfg)) hdr_ok = 0;
      if (proto_cfg == ProtoTcp) begin
        if (q >= 4 && q <= 7) seq = (seq << 8) | b;
        if (q >= 8 && q <= 11) ack = (ack << 8) | b;
        if (q == 12) begin
          l4_hdr_len = (b >> 4) * 4;
          if (l4_hdr_len < 20) hdr_ok = 0;
        end
        if (q == 13) flags = b;
        if (q < 20 || q < l4_hdr_len) return;
        if ((flags & flags_cfg) != flags_cfg) return;
        idx = int'(q - l4_hdr_len);
        avail = int'(ip_len) - int'(ip_hdr_len) - int'(l4_hdr_len);
      end else begin
        if (q == 4) udp_len = b << 8;
        if (q == 5) udp_len |= b;
        if (q < 8) return;
        idx = int'(q - 8);
        avail = int'(udp_len) - 8;
      end
      if (!hdr_ok || ether_kind != EtherIpv4) return;
      if (idx >= avail || emitted >= max_payload_cfg) return;
      emitted++;
      it = '0;
      it.payload_byte = b[7:0];
      owed.push_back(it);
    endfunction

    function void close_frame();
      rxffp_item_t it;
      it = '0;
      it.verdict = VerdReject;
      if (pos >= MinFrame) begin
        if (ether_kind == EtherArp) begin
          if (arp_op == 2 && arp_ip == gateway_ip_cfg) begin
            gw_mac = arp_mac;
            it.verdict = VerdArp;
          end
        end else if (ether_kind == EtherIpv4 && hdr_ok) begin
          if (proto_cfg == ProtoTcp && pos >= 34 + ip_hdr_len) begin
            it.verdict = ((flags & flags_cfg) == flags_cfg) ? VerdTcp : VerdNoFlags;
            it.tcp_flags = flags[7:0];
            it.seq_number = seq;
            it.ack_number = ack;
          end else if (proto_cfg == ProtoUdp && pos >= 22 + ip_hdr_len) begin
            it.verdict = VerdUdp;
          end
        end
      end
      it.item_kind = 1'b1;
      it.payload_count = emitted[11:0];
      it.gateway_mac = gw_mac;
      it.frame_end = 1'b1;
      verdict_hits[it.verdict]++;
      owed.push_back(it);
      clear_frame();
    endfunction

    function void note_byte(bit [7:0] b, bit last);
      if (pos < MaxFrame) begin
        parse_byte(32'(b));
        pos++;
      end
      if (last) close_frame();
    endfunction

    function void check_item(rxffp_item_t got);
      rxffp_item_t want;
      checked++;
      if (!got.item_kind) payload_seen++;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR %0t: unexpected transfer kind=%0b data=%0h", $realtime,
                   got.item_kind, got.payload_byte);
        return;
      end
      want = owed.pop_front();
      if (got.item_kind != want.item_kind || got.payload_byte != want.payload_byte ||
          got.verdict != want.verdict || got.tcp_flags != want.tcp_flags ||
          got.seq_number != want.seq_number || got.ack_number != want.ack_number ||
          got.payload_count != want.payload_count ||
          got.gateway_mac != want.gateway_mac || got.frame_end != want.frame_end) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR %0t: mismatch", $realtime);
          $display("  exp kind=%0b byte=%02h verd=%0d fl=%02h end=%0b",
                   want.item_kind, want.payload_byte, want.verdict, want.tcp_flags,
                   want.frame_end);
          $display("      seq=%08h ack=%08h cnt=%0d mac=%012h",
                   want.seq_number, want.ack_number, want.payload_count,
                   want.gateway_mac);
          $display("  got kind=%0b byte=%02h verd=%0d fl=%02h end=%0b",
                   got.item_kind, got.payload_byte, got.verdict, got.tcp_flags,
                   got.frame_end);
          $display("      seq=%08h ack=%08h cnt=%0d mac=%012h",
                   got.seq_number, got.ack_number, got.payload_count,
                   got.gateway_mac);
        end
      end
    endfunction
  endclass

  localparam int WatchdogLimit = 20000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [7:0]   s_axis_tdata_i = '0;
  logic         s_axis_tlast_i = 1'b0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [143:0] m_axis_tdata_o;
  logic         m_axis_tuser_o;
  logic         m_axis_tlast_o;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_idx_i = '0;
  logic [31:0]  cfg_data_i = '0;

  rx_frame_filter_parser_top dut (.*);

  frame_scoreboard sb = new();

  // frame under construction and stimulus knobs
  bit [7:0] frame_q[$];
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int frames_sent = 0;
  int bytes_sent = 0;
  int idle_cycles = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // receiver stall pattern, changed on the falling edge only
  always @(negedge clk_i) m_axis_tready_i <= ($urandom_range(99) >= rx_idle_pct);

  // accepted transfers on both sides go to the scoreboard
  always @(posedge clk_i) begin
    rxffp_item_t got;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o)
      sb.note_byte(s_axis_tdata_i, s_axis_tlast_i);
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.item_kind     = m_axis_tuser_o;
      got.payload_byte  = m_axis_tdata_o[7:0];
      got.verdict       = m_axis_tdata_o[10:8];
      got.tcp_flags     = m_axis_tdata_o[18:11];
      got.seq_number    = m_axis_tdata_o[50:19];
      got.ack_number    = m_axis_tdata_o[82:51];
      got.payload_count = m_axis_tdata_o[94:83];
      got.gateway_mac   = m_axis_tdata_o[142:95];
      got.frame_end     = m_axis_tlast_o;
      sb.check_item(got);
    end
  end

  // watchdog: cycles in a row with no transfer on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("timeout: no transfer for %0d cycles", WatchdogLimit);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    sb.write_reg(idx, val);
  endtask

  task automatic end_writes();
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // stop sending, wait for every owed result, then let the result queue settle
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    wait (sb.owed.size() == 0);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic send_byte(bit [7:0] b, bit last);
    @(negedge clk_i);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i = b;
    s_axis_tlast_i = last;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // frames follow each other with no gap unless the sender idles
  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
    frames_sent++;
    bytes_sent += frame_q.size();
  endtask

  task automatic push_rand(int n);
    repeat (n) frame_q.push_back(8'($urandom_range(255)));
  endtask

  task automatic push16(bit [15:0] v);
    frame_q.push_back(v[15:8]);
    frame_q.push_back(v[7:0]);
  endtask

  task automatic push32(bit [31:0] v);
    push16(v[31:16]);
    push16(v[15:0]);
  endtask

  // ipv4 frame carrying a tcp segment or udp datagram; len_adj shifts the length field
  task automatic build_ip(bit [7:0] proto, bit [15:0] sport, bit [15:0] dport,
                          bit [7:0] tflags, int ihl, int doff, int paylen,
                          int len_adj, int pad);
    int l4len;
    frame_q.delete();
    push_rand(12);
    push16(EtherIpv4);
    l4len = (proto == ProtoTcp) ? doff * 4 : 8;
    frame_q.push_back({4'h4, ihl[3:0]});
    push_rand(1);
    push16(16'(ihl * 4 + l4len + paylen + len_adj));
    push_rand(5);
    frame_q.push_back(proto);
    push_rand(10 + (ihl - 5) * 4);
    push16(sport);
    push16(dport);
    if (proto == ProtoTcp) begin
      push32($urandom);
      push32($urandom);
      frame_q.push_back({doff[3:0], 4'($urandom_range(15))});
      frame_q.push_back(tflags);
      push_rand(6 + (doff - 5) * 4);
    end else begin
      push16(16'(8 + paylen + len_adj));
      push_rand(2);
    end
    push_rand(paylen + pad);
  endtask

  task automatic build_arp(bit [15:0] op, bit [31:0] sender_ip);
    frame_q.delete();
    push_rand(12);
    push16(EtherArp);
    push16(16'h0001);
    push16(EtherIpv4);
    frame_q.push_back(8'd6);
    frame_q.push_back(8'd4);
    push16(op);
    push_rand(6);
    push32(sender_ip);
    push_rand(10);
  endtask

  // a frame aimed at the current settings, sometimes off target or damaged
  task automatic build_random_frame();
    int pick, paylen, ihl, doff, cut;
    bit [7:0] proto, tflags;
    bit [15:0] sport, dport;
    pick = $urandom_range(99);
    if (pick < 10) begin
      build_arp(($urandom_range(3) != 0) ? 16'd2 : 16'($urandom),
                ($urandom_range(1) != 0) ? sb.gateway_ip_cfg : $urandom);
    end else if (pick < 15) begin
      frame_q.delete();
      push_rand($urandom_range(80, 1));
    end else begin
      if (sb.proto_cfg == ProtoTcp || sb.proto_cfg == ProtoUdp)
        proto = ($urandom_range(9) != 0) ? sb.proto_cfg : 8'($urandom);
      else
        proto = ($urandom_range(1) != 0) ? ProtoTcp : ProtoUdp;
      sport = ($urandom_range(9) != 0) ? sb.remote_port_cfg : 16'($urandom);
      dport = ($urandom_range(9) != 0) ? sb.local_port_cfg : 16'($urandom);
      tflags = 8'($urandom);
      if ($urandom_range(9) < 7) tflags |= sb.flags_cfg;
      ihl = ($urandom_range(4) == 0) ? $urandom_range(15, 5) : 5;
      doff = ($urandom_range(4) == 0) ? $urandom_range(15, 5) : 5;
      paylen = ($urandom_range(19) == 0) ? $urandom_range(300) : $urandom_range(40);
      build_ip(proto, sport, dport, tflags, ihl, doff, paylen,
               ($urandom_range(9) == 0) ? -int'($urandom_range(30)) : 0,
               ($urandom_range(3) == 0) ? $urandom_range(8) : 0);
      if (pick >= 88) begin
        // damage: truncate, or break one byte anywhere
        cut = $urandom_range(frame_q.size() - 1, 1);
        if ($urandom_range(1) != 0) while (frame_q.size() > cut) void'(frame_q.pop_back());
        else frame_q[cut] = 8'($urandom);
      end
    end
  endtask

  task automatic random_settings();
    write_reg(RegExpectProtocol, ($urandom_range(5) == 0) ? 32'($urandom_range(255)) :
              (($urandom_range(1) != 0) ? ProtoTcp : ProtoUdp));
    write_reg(RegLocalPort, ($urandom_range(4) == 0) ? 32'hFFFF : 32'($urandom_range(65535)));
    write_reg(RegRemotePort, ($urandom_range(4) == 0) ? 32'h0 : 32'($urandom_range(65535)));
    write_reg(RegRequiredFlags, ($urandom_range(3) == 0) ? 32'hFF :
              32'($urandom_range(255) & $urandom_range(255)));
    write_reg(RegMaxPayload, ($urandom_range(3) == 0) ? 32'($urandom_range(1) * 2048) :
              32'($urandom_range(60)));
    write_reg(RegGatewayIp, ($urandom_range(4) == 0) ? 32'hFFFFFFFF : $urandom);
    end_writes();
  endtask

  initial begin
    int target;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed frames at the reset settings
    build_ip(ProtoTcp, 80, 40000, 8'h18, 5, 5, 10, 0, 0);  send_frame();
    build_arp(16'd2, 32'd167772674);                       send_frame();
    build_arp(16'd1, 32'd167772674);                       send_frame();
    build_arp(16'd2, 32'd167772675);                       send_frame();
    frame_q.delete(); push_rand(20);                       send_frame();
    frame_q.delete(); push_rand(1);                        send_frame();
    build_ip(ProtoTcp, 80, 40000, 8'hFF, 6, 7, 12, 0, 0);  send_frame();
    // header length nibble below five
    build_ip(ProtoTcp, 80, 40000, 8'h10, 5, 5, 8, 0, 0);
    frame_q[14] = 8'h44;                                   send_frame();
    // ip version other than four
    build_ip(ProtoTcp, 80, 40000, 8'h10, 5, 5, 8, 0, 0);
    frame_q[14] = 8'h65;                                   send_frame();
    build_ip(ProtoTcp, 80, 40000, 8'h10, 5, 4, 8, 0, 0);   send_frame();
    // ends inside the tcp header
    build_ip(ProtoTcp, 80, 40000, 8'h10, 5, 5, 0, 0, 0);
    repeat (10) void'(frame_q.pop_back());                 send_frame();
    build_ip(ProtoTcp, 80, 40000, 8'h10, 5, 5, 6, -12, 0); send_frame();
    build_ip(ProtoTcp, 80, 40000, 8'h10, 5, 5, 5, 0, 7);   send_frame();
    build_ip(ProtoTcp, 81, 40000, 8'h10, 5, 5, 5, 0, 0);   send_frame();
    // longer than the largest frame the block parses
    build_ip(ProtoTcp, 80, 40000, 8'h10, 5, 5, 2100, 0, 0); send_frame();
    drain();

    write_reg(RegRequiredFlags, 32'h12);
    write_reg(RegMaxPayload, 32'd0);
    end_writes();
    build_ip(ProtoTcp, 80, 40000, 8'h02, 5, 5, 6, 0, 0);   send_frame();
    build_ip(ProtoTcp, 80, 40000, 8'h12, 5, 5, 6, 0, 0);   send_frame();
    drain();
    write_reg(RegExpectProtocol, ProtoUdp);
    write_reg(RegMaxPayload, 32'd2048);
    end_writes();
    build_ip(ProtoUdp, 80, 40000, 8'h0, 5, 5, 9, 0, 3);    send_frame();
    build_ip(ProtoUdp, 80, 40000, 8'h0, 5, 5, 9, -9, 0);   send_frame();
    build_ip(ProtoUdp, 80, 40001, 8'h0, 5, 5, 9, 0, 0);    send_frame();
    build_ip(ProtoUdp, 80, 40000, 8'h0, 5, 5, 2100, 0, 0); send_frame();
    drain();
    write_reg(RegExpectProtocol, 32'd99);
    end_writes();
    build_ip(8'd99, 80, 40000, 8'h0, 5, 5, 9, 0, 0);       send_frame();
    drain();

    // random frames: six settings, two per idling pattern
    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin tx_idle_pct = 7;  rx_idle_pct = 55; end
        1: begin tx_idle_pct = 55; rx_idle_pct = 7;  end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      random_settings();
      target = bytes_sent + 200;
      while (bytes_sent < target) begin
        build_random_frame();
        send_frame();
      end
      drain();
    end

    $display("sent %0d frames in %0d bytes, checked %0d results (%0d payload)",
             frames_sent, bytes_sent, sb.checked, sb.payload_seen);
    $display("verdicts: reject %0d, arp %0d, tcp %0d, udp %0d, flags missing %0d",
             sb.verdict_hits[VerdReject], sb.verdict_hits[VerdArp], sb.verdict_hits[VerdTcp],
             sb.verdict_hits[VerdUdp], sb.verdict_hits[VerdNoFlags]);
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.owed.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
